@@ hw/rtl/aes_pkg.sv @@
package aes_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int ROUND_KEY_WORDS = 60;
    localparam int RK_AW = $clog2(ROUND_KEY_WORDS);

    localparam logic [1:0] MODE_128 = 2'd0;
    localparam logic [1:0] MODE_192 = 2'd1;

    localparam logic [2:0] CFG_MODE = 3'd0;
    localparam logic [2:0] CFG_KEY0 = 3'd1;
    localparam logic [2:0] CFG_KEY1 = 3'd2;
    localparam logic [2:0] CFG_KEY2 = 3'd3;
    localparam logic [2:0] CFG_KEY3 = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KLOAD,
        ST_KEXP,
        ST_INIT,
        ST_ROUND,
        ST_DONE
    } state_t;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] p;
        x = a;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = xtime(x);
        end
        return p;
    endfunction

    // Walks the powers of 3 and of its inverse together to fill the S-box,
    // entry a at bits 8*a+7 down to 8*a.
    function automatic logic [2047:0] build_sbox_tbl(input logic inverse);
        logic [2047:0] t;
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] v;
        t = '0;
        p = 8'h01;
        q = 8'h01;
        for (int n = 0; n < 255; n++) begin
            p = p ^ xtime(p);
            q = q ^ {q[6:0], 1'b0};
            q = q ^ {q[5:0], 2'b00};
            q = q ^ {q[3:0], 4'h0};
            if (q[7]) q = q ^ 8'h09;
            v = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
                ^ {q[3:0], q[7:4]} ^ 8'h63;
            if (inverse)
                t[{v, 3'b000} +: 8] = p;
            else
                t[{p, 3'b000} +: 8] = v;
        end
        if (inverse)
            t[{8'h63, 3'b000} +: 8] = 8'h00;
        else
            t[7:0] = 8'h63;
        return t;
    endfunction

    localparam logic [2047:0] SBOX_TBL = build_sbox_tbl(1'b0);
    localparam logic [2047:0] INV_SBOX_TBL = build_sbox_tbl(1'b1);

    function automatic logic [7:0] sbox(input logic [7:0] a);
        return SBOX_TBL[{a, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        return INV_SBOX_TBL[{a, 3'b000} +: 8];
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

@@ hw/rtl/aes_block_cipher_core.sv @@
// On the first beat after a key or mode write, the key is first loaded and expanded one word a
// cycle into the round-key memory before the rounds start. A new block is taken only when idle.
// The shared round unit computes each round from four round-key words, because the round-key
// memory is read one 32-bit word a cycle. Reset clears the mode, key, state and output-valid
// registers and marks the keys stale.
module aes_block_cipher_core
    import aes_pkg::*;
#(
    parameter int RK_WORDS = ROUND_KEY_WORDS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_high,
    output logic [63:0] result_low
);

    localparam int AW = $clog2(RK_WORDS);

    logic [1:0]   mode_reg;
    logic [63:0]  key_reg [4];
    logic         expanded_reg;
    state_t       state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [3:0]   round_reg, round_next;
    logic [2:0]   nkc_reg, nkc_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic         dec_reg;
    logic [127:0] st_reg, st_next;
    logic [31:0]  win_reg [8];
    logic [31:0]  rk_mem [RK_WORDS];
    logic [127:0] rk_reg;
    logic         out_valid_reg;
    logic [127:0] res_reg;

    logic [3:0] nk, nr;
    logic       rk_we;
    logic [31:0] rk_wdata, t_word;
    logic [AW-1:0] rk_waddr;
    logic       done_fire;

    assign nk = (mode_reg == MODE_128) ? 4'd4 : ((mode_reg == MODE_192) ? 4'd6 : 4'd8);
    assign nr = nk + 4'd6;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
            key_reg <= '{default: '0};
            expanded_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODE: begin mode_reg <= cfg_data[1:0]; expanded_reg <= 1'b0; end
                    CFG_KEY0: begin key_reg[0] <= cfg_data; expanded_reg <= 1'b0; end
                    CFG_KEY1: begin key_reg[1] <= cfg_data; expanded_reg <= 1'b0; end
                    CFG_KEY2: begin key_reg[2] <= cfg_data; expanded_reg <= 1'b0; end
                    CFG_KEY3: begin key_reg[3] <= cfg_data; expanded_reg <= 1'b0; end
                    default: ;
                endcase
            end
            else if (state_reg == ST_KEXP && state_next == ST_INIT)
            begin
                expanded_reg <= 1'b1;
            end
        end
    end

    // One new key word per cycle from the sliding window of the last Nk words.
    always_comb
    begin
        t_word = win_reg[nk[2:0] - 3'd1];
        if (nkc_reg == 3'd0)
            t_word = sbox_word({t_word[23:0], t_word[31:24]}) ^ {rcon_reg, 24'h0};
        else if (nk == 4'd8 && nkc_reg == 3'd4)
            t_word = sbox_word(t_word);
    end

    always_comb
    begin
        rk_we = 1'b0;
        rk_waddr = idx_reg;
        rk_wdata = t_word ^ win_reg[0];
        if (state_reg == ST_KLOAD)
        begin
            rk_we = 1'b1;
            rk_wdata = idx_reg[0] ? key_reg[idx_reg[2:1]][31:0] : key_reg[idx_reg[2:1]][63:32];
        end
        else if (state_reg == ST_KEXP)
        begin
            rk_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rk_we)
            rk_mem[rk_waddr] <= rk_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (rk_we)
        begin
            for (int i = 0; i < 7; i++)
            begin
                if (i + 1 < int'(nk))
                    win_reg[i] <= win_reg[i + 1];
            end
            win_reg[nk[2:0] - 3'd1] <= rk_wdata;
        end
    end

    // Round-key fetch: four words into rk_reg, one per cycle.
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_word;
    always_ff @(posedge clk)
    begin
        rd_word <= rk_mem[rd_addr];
    end

    // Round unit.
    logic [7:0] sb [16];
    logic [7:0] sr [16];
    logic [7:0] mc [16];
    logic [7:0] s  [16];
    logic [127:0] after_sub, after_mix, key_now;
    logic last_round;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
            s[i] = st_reg[127 - 8*i -: 8];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
            begin
                if (dec_reg)
                    sr[r + 4*((c + r) % 4)] = inv_sbox(s[r + 4*c]);
                else
                    sr[r + 4*c] = sbox(s[r + 4*((c + r) % 4)]);
            end
        for (int i = 0; i < 16; i++)
            after_sub[127 - 8*i -: 8] = sr[i];
        key_now = {rk_reg[95:0], rd_word};
        for (int i = 0; i < 16; i++)
            sb[i] = dec_reg ? (sr[i] ^ key_now[127 - 8*i -: 8]) : sr[i];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                if (dec_reg)
                    mc[4*c + r] = gmul(8'h0E, sb[4*c + r]) ^ gmul(8'h0B, sb[4*c + (r+1)%4])
                                ^ gmul(8'h0D, sb[4*c + (r+2)%4])
                                ^ gmul(8'h09, sb[4*c + (r+3)%4]);
                else
                    mc[4*c + r] = gmul(8'h02, sb[4*c + r]) ^ gmul(8'h03, sb[4*c + (r+1)%4])
                                ^ sb[4*c + (r+2)%4] ^ sb[4*c + (r+3)%4];
            end
        for (int i = 0; i < 16; i++)
            after_mix[127 - 8*i -: 8] = mc[i];
    end

    assign last_round = (round_reg == nr);
    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        round_next = round_reg;
        nkc_next = nkc_reg;
        rcon_next = rcon_reg;
        st_next = st_reg;
        rd_addr = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    st_next = {block_high, block_low};
                    idx_next = '0;
                    state_next = expanded_reg ? ST_INIT : ST_KLOAD;
                end
            end
            ST_KLOAD:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == AW'(nk - 4'd1))
                begin
                    nkc_next = '0;
                    rcon_next = 8'h01;
                    state_next = ST_KEXP;
                end
            end
            ST_KEXP:
            begin
                idx_next = idx_reg + 1'b1;
                nkc_next = (nkc_reg == nk[2:0] - 3'd1 || (nk == 4'd8 && nkc_reg == 3'd7))
                    ? 3'd0 : nkc_reg + 3'd1;
                if (nkc_reg == 3'd0)
                    rcon_next = xtime(rcon_reg);
                if (int'(idx_reg) == 4*(int'(nr) + 1) - 1)
                begin
                    idx_next = '0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                // Fetch the four words of the first round key; add it once the fourth word has arrived.
                rd_addr = AW'({2'b0, dec_reg ? nr : 4'd0} * 4 + idx_reg[1:0]);
                if (idx_reg[2:0] == 3'd4)
                begin
                    st_next = st_reg ^ key_now;
                    round_next = 4'd1;
                    idx_next = '0;
                    state_next = ST_ROUND;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_ROUND:
            begin
                rd_addr = AW'({2'b0, dec_reg ? (nr - round_reg) : round_reg} * 4
                              + idx_reg[1:0]);
                if (idx_reg[2:0] == 3'd4)
                begin
                    if (dec_reg)
                        st_next = last_round ? (after_sub ^ key_now) : after_mix;
                    else
                        st_next = (last_round ? after_sub : after_mix) ^ key_now;
                    idx_next = '0;
                    round_next = round_reg + 4'd1;
                    if (last_round)
                        state_next = ST_DONE;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (done_fire)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (done_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        round_reg <= round_next;
        nkc_reg <= nkc_next;
        rcon_reg <= rcon_next;
        st_reg <= st_next;
        if (state_reg == ST_IDLE)
            dec_reg <= req_type;
        rk_reg <= key_now;
        if (done_fire)
            res_reg <= st_reg;
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign result_high = res_reg[127:64];
    assign result_low = res_reg[63:0];

endmodule
